// ===== hw/rtl/gtp_pkg.sv =====
// ----------------------------------------------------------------------------
// gtp_pkg
// Shared types and constants of the go-to-point velocity controller.
// ----------------------------------------------------------------------------
package gtp_pkg;

    localparam int FRAC_BITS   = 8;
    localparam int HEAD_W      = 18;
    localparam int SPEED_W     = 16;
    localparam int TURN_W      = 24;
    localparam int GAIN_W      = 16;
    localparam int PRESCALE    = 24;
    localparam int INV_GAIN    = 39796;
    localparam int CFG_IDX_W   = 3;
    localparam int ATAN_W      = 22;
    localparam int ANG_W       = 26;
    localparam int ERR_W       = 28;
    localparam int TURN_SHIFT  = 28 - FRAC_BITS;
    localparam int QUARTER_Q16 = 90 * 65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GOAL_X    = 3'd0,
        REG_GOAL_Y    = 3'd1,
        REG_TOLERANCE = 3'd2,
        REG_SPEED_GN  = 3'd3,
        REG_TURN_GN   = 3'd4,
        REG_SPEED_LIM = 3'd5
    } cfg_reg_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_ITER,
        BK_MUL,
        BK_RND,
        BK_OUT
    } back_state_t;

    // Gains and limit handed from the front to the back
    typedef struct packed {
        logic [GAIN_W-1:0]  speed_gain;
        logic [GAIN_W-1:0]  turn_gain;
        logic [SPEED_W-1:0] speed_limit;
    } gain_set_t;

    // atan(2^-i) in degrees, Q.16, rounded
    function automatic logic [ATAN_W-1:0] atan_q16(input logic [4:0] i);
        logic [ATAN_W-1:0] v;
        case (i)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/gtp_front.sv =====
// ----------------------------------------------------------------------------
// gtp_front
// Configuration registers, pose state and tick classification into jobs.
// ----------------------------------------------------------------------------
module gtp_front #(
    parameter int POS_WIDTH = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic                         operation,
    input  logic [POS_WIDTH-1:0]         pos_x,
    input  logic [POS_WIDTH-1:0]         pos_y,
    input  logic [gtp_pkg::HEAD_W-1:0]   heading_raw,
    input  logic                         cfg_we,
    input  logic [gtp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [POS_WIDTH-1:0]         cfg_data,
    output logic                         job_push,
    output logic [2*POS_WIDTH+gtp_pkg::HEAD_W+3:0] job_data,
    output gtp_pkg::gain_set_t           gains
);
    import gtp_pkg::*;

    localparam int DIFF_W = POS_WIDTH + 1;
    localparam int CMP_W  = POS_WIDTH + 2;

    logic signed [POS_WIDTH-1:0] goal_x_reg, goal_y_reg;
    logic [GAIN_W-1:0]           tol_reg, sgain_reg, tgain_reg, slim_reg;
    logic signed [POS_WIDTH-1:0] robot_x_reg, robot_y_reg;
    logic signed [HEAD_W-1:0]    head_reg;
    logic                        reached_reg, pending_reg;

    logic signed [HEAD_W-1:0]    head_neg;
    logic signed [CMP_W-1:0]     px, py, gx, gy, tol_s;
    logic                        reached_next;
    logic signed [DIFF_W-1:0]    dx, dy;
    logic                        fresh;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg <= '0;
            goal_y_reg <= '0;
            tol_reg    <= 16'd1408;
            sgain_reg  <= 16'd3686;
            tgain_reg  <= 16'd819;
            slim_reg   <= 16'd6400;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GOAL_X:    goal_x_reg <= $signed(cfg_data);
                REG_GOAL_Y:    goal_y_reg <= $signed(cfg_data);
                REG_TOLERANCE: tol_reg    <= cfg_data[GAIN_W-1:0];
                REG_SPEED_GN:  sgain_reg  <= cfg_data[GAIN_W-1:0];
                REG_TURN_GN:   tgain_reg  <= cfg_data[GAIN_W-1:0];
                REG_SPEED_LIM: slim_reg   <= cfg_data[GAIN_W-1:0];
                default:       ;
            endcase
        end
    end

    assign gains = '{speed_gain: sgain_reg, turn_gain: tgain_reg, speed_limit: slim_reg};

    // Negate heading, saturate the most negative code
    always_comb
    begin
        if (heading_raw == {1'b1, {(HEAD_W-1){1'b0}}})
            head_neg = {1'b0, {(HEAD_W-1){1'b1}}};
        else
            head_neg = -$signed(heading_raw);
    end

    // Strict arrival box test on the incoming pose
    always_comb
    begin
        px    = CMP_W'($signed(pos_x));
        py    = CMP_W'($signed(pos_y));
        gx    = CMP_W'(goal_x_reg);
        gy    = CMP_W'(goal_y_reg);
        tol_s = $signed(CMP_W'(tol_reg));
        reached_next = (px > gx - tol_s) && (px < gx + tol_s) &&
                       (py > gy - tol_s) && (py < gy + tol_s);
    end

    // Update pose state and pending mark
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            robot_x_reg <= '0;
            robot_y_reg <= '0;
            head_reg    <= '0;
            reached_reg <= 1'b1;
            pending_reg <= 1'b1;
        end
        else if (accept)
        begin
            if (!operation)
            begin
                robot_x_reg <= $signed(pos_x);
                robot_y_reg <= $signed(pos_y);
                head_reg    <= head_neg;
                reached_reg <= reached_next;
                pending_reg <= 1'b1;
            end
            else if (fresh)
            begin
                pending_reg <= 1'b0;
            end
        end
    end

    // Build a job for every tick
    always_comb
    begin
        fresh    = !reached_reg && pending_reg;
        dx       = DIFF_W'(goal_x_reg) - DIFF_W'(robot_x_reg);
        dy       = DIFF_W'(goal_y_reg) - DIFF_W'(robot_y_reg);
        job_push = accept && operation;
        job_data = {fresh, reached_reg, head_reg, dy, dx};
    end

endmodule

// ===== hw/rtl/gtp_queue.sv =====
// ----------------------------------------------------------------------------
// gtp_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module gtp_queue #(
    parameter int DATA_W = 72
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    output logic [DATA_W-1:0] rd_data,
    output logic              full,
    output logic              empty
);
    import gtp_pkg::*;

    logic [DATA_W-1:0] slot_reg [2];
    logic              wr_ptr_reg, rd_ptr_reg;
    logic [1:0]        count_reg;

    // Store written jobs
    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= !wr_ptr_reg;
            if (rd_en)
                rd_ptr_reg <= !rd_ptr_reg;
            if (wr_en && !rd_en)
                count_reg <= count_reg + 2'd1;
            else if (rd_en && !wr_en)
                count_reg <= count_reg - 2'd1;
        end
    end

    assign rd_data = slot_reg[rd_ptr_reg];
    assign full    = count_reg == 2'd2;
    assign empty   = count_reg == 2'd0;

endmodule

// ===== hw/rtl/gtp_back.sv =====
// ----------------------------------------------------------------------------
// gtp_back
// Vectoring CORDIC, gain multiplies, saturation and the result register.
// ----------------------------------------------------------------------------
module gtp_back #(
    parameter int POS_WIDTH    = 24,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         job_empty,
    input  logic [2*POS_WIDTH+gtp_pkg::HEAD_W+3:0] job_data,
    output logic                         job_pop,
    input  gtp_pkg::gain_set_t           gains,
    input  logic                         pop,
    output logic                         empty,
    output logic [gtp_pkg::SPEED_W-1:0]  linear_speed,
    output logic [gtp_pkg::TURN_W-1:0]   turn_rate,
    output logic                         target_reached,
    output logic                         fresh_command
);
    import gtp_pkg::*;

    localparam int DIFF_W = POS_WIDTH + 1;
    localparam int CW     = DIFF_W + PRESCALE + 2;
    localparam int MAG_W  = CW - 16;
    localparam int MP_W   = MAG_W + 16;
    localparam int DIST_W = MP_W + 1 - 24;
    localparam int SP_W   = DIST_W + GAIN_W;
    localparam int TP_W   = ERR_W + GAIN_W + 1;
    localparam int CNT_W  = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    back_state_t state_reg, state_next;

    // Job fields
    logic signed [DIFF_W-1:0] job_dx, job_dy;
    logic signed [HEAD_W-1:0] job_head;
    logic                     job_reached, job_fresh;

    logic signed [CW-1:0]     x_reg, y_reg;
    logic signed [ANG_W-1:0]  z_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic signed [HEAD_W-1:0] head_reg;
    logic                     reached_reg, fresh_reg;
    logic [MP_W-1:0]          mprod_reg;
    logic signed [TP_W-1:0]   tprod_reg;
    logic [SP_W-1:0]          sprod_reg;
    logic signed [TURN_W-1:0] turn_reg;

    logic                     out_valid_reg;
    logic [SPEED_W-1:0]       speed_out_reg;
    logic [TURN_W-1:0]        turn_out_reg;
    logic                     reached_out_reg, fresh_out_reg;

    logic signed [CW-1:0]     xin, yin, xs, ys;
    logic                     zero_vec, last_step, out_load;
    logic signed [ANG_W-1:0]  atan_s;
    logic signed [ERR_W-1:0]  err;
    logic [MP_W:0]            dist_sum;
    logic [DIST_W-1:0]        dist_val;
    logic signed [TP_W-1:0]   turn_round;
    logic [SP_W:0]            speed_sum;
    logic [SP_W-12:0]         speed_raw;
    logic [SPEED_W-1:0]       speed_sat;

    assign {job_fresh, job_reached, job_head, job_dy, job_dx} = job_data;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
                if (!job_empty)
                begin
                    if (!job_fresh)
                        state_next = BK_OUT;
                    else if (zero_vec)
                        state_next = BK_MUL;
                    else
                        state_next = BK_ITER;
                end
            BK_ITER: if (last_step) state_next = BK_MUL;
            BK_MUL:  state_next = BK_RND;
            BK_RND:  state_next = BK_OUT;
            BK_OUT:  if (out_load) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        job_pop  = (state_reg == BK_IDLE) && !job_empty;
        out_load = (state_reg == BK_OUT) && (!out_valid_reg || pop);
        last_step = cnt_reg == CNT_W'(CORDIC_STEPS - 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BK_IDLE;
        else
            state_reg <= state_next;
    end

    // Prescale and rotate into the right half plane
    always_comb
    begin
        zero_vec = (job_dx == '0) && (job_dy == '0);
        xin = CW'(job_dy) <<< PRESCALE;
        yin = CW'(job_dx) <<< PRESCALE;
        xs  = x_reg >>> cnt_reg;
        ys  = y_reg >>> cnt_reg;
        atan_s = $signed(ANG_W'(atan_q16(5'(cnt_reg))));
    end

    // Arithmetic for the multiply and rounding steps
    always_comb
    begin
        err = ERR_W'(z_reg) - (ERR_W'(head_reg) <<< (16 - FRAC_BITS));
        dist_sum = (MP_W+1)'(mprod_reg) + (MP_W+1)'(1 << 23);
        dist_val = dist_sum[MP_W:24];
        turn_round = (tprod_reg + TP_W'(1 << (TURN_SHIFT - 1))) >>> TURN_SHIFT;
        speed_sum = (SP_W+1)'(sprod_reg) + (SP_W+1)'(1 << 11);
        speed_raw = speed_sum[SP_W:12];
        if (speed_raw > (SP_W-11)'(gains.speed_limit))
            speed_sat = gains.speed_limit;
        else
            speed_sat = speed_raw[SPEED_W-1:0];
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            BK_IDLE:
            begin
                head_reg    <= job_head;
                reached_reg <= job_reached;
                fresh_reg   <= job_fresh;
                cnt_reg     <= '0;
                sprod_reg   <= '0;
                turn_reg    <= '0;
                if (zero_vec)
                begin
                    x_reg <= '0;
                    y_reg <= '0;
                    z_reg <= '0;
                end
                else if (xin < 0)
                begin
                    if (yin >= 0)
                    begin
                        x_reg <= yin;
                        y_reg <= -xin;
                        z_reg <= ANG_W'(QUARTER_Q16);
                    end
                    else
                    begin
                        x_reg <= -yin;
                        y_reg <= xin;
                        z_reg <= -ANG_W'(QUARTER_Q16);
                    end
                end
                else
                begin
                    x_reg <= xin;
                    y_reg <= yin;
                    z_reg <= '0;
                end
            end
            BK_ITER:
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (y_reg >= 0)
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + atan_s;
                end
                else
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - atan_s;
                end
            end
            BK_MUL:
            begin
                mprod_reg <= MP_W'(x_reg[CW-1:16]) * MP_W'(INV_GAIN);
                tprod_reg <= TP_W'(err) * $signed(TP_W'(gains.turn_gain));
            end
            BK_RND:
            begin
                sprod_reg <= SP_W'(dist_val) * SP_W'(gains.speed_gain);
                if (turn_round > TP_W'(2**(TURN_W-1) - 1))
                    turn_reg <= {1'b0, {(TURN_W-1){1'b1}}};
                else if (turn_round < -TP_W'(2**(TURN_W-1)))
                    turn_reg <= {1'b1, {(TURN_W-1){1'b0}}};
                else
                    turn_reg <= turn_round[TURN_W-1:0];
            end
            BK_OUT: ;
            default: ;
        endcase
    end

    // Hold the finished result until popped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            speed_out_reg   <= speed_sat;
            turn_out_reg    <= turn_reg;
            reached_out_reg <= reached_reg;
            fresh_out_reg   <= fresh_reg;
        end
    end

    assign empty          = !out_valid_reg;
    assign linear_speed   = speed_out_reg;
    assign turn_rate      = turn_out_reg;
    assign target_reached = reached_out_reg;
    assign fresh_command  = fresh_out_reg;

endmodule

// ===== hw/rtl/go_to_point_velocity_controller_core.sv =====
// ----------------------------------------------------------------------------
// go_to_point_velocity_controller_core
// Proportional go-to-goal controller: pose and tick items in, commands out.
//
//   channel  handshake          payload
//   input    push / full        operation, pos_x, pos_y, heading_raw
//   result   pop / empty        linear_speed, turn_rate, target_reached,
//                               fresh_command
//   config   cfg_valid/ready    cfg_index, cfg_data
//
// Pose items update the pose registers and give no result. A tick becomes
// a job in a two-entry queue; the back runs a setup step, CORDIC_STEPS
// iterations (skipped for a zero offset), a multiply and a round step and
// an output step for a fresh tick, and goes from setup straight to output
// for any other tick. The CORDIC loop sets the rate.
// Reset clears all control state; no clearing pass. full rises when the
// queue holds two jobs; a result held in the output register stalls the back.
// ----------------------------------------------------------------------------
module go_to_point_velocity_controller_core #(
    parameter int POS_WIDTH    = 24,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          operation,
    input  logic [POS_WIDTH-1:0]          pos_x,
    input  logic [POS_WIDTH-1:0]          pos_y,
    input  logic [gtp_pkg::HEAD_W-1:0]    heading_raw,
    output logic                          empty,
    input  logic                          pop,
    output logic [gtp_pkg::SPEED_W-1:0]   linear_speed,
    output logic [gtp_pkg::TURN_W-1:0]    turn_rate,
    output logic                          target_reached,
    output logic                          fresh_command,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [gtp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [POS_WIDTH-1:0]          cfg_data
);
    import gtp_pkg::*;

    localparam int JOB_W = 2 * POS_WIDTH + HEAD_W + 4;

    logic             job_push, job_pop, job_full, job_empty;
    logic [JOB_W-1:0] job_in, job_out;
    gain_set_t        gains;

    assign cfg_ready = 1'b1;
    assign full      = job_full;

    gtp_front #(
        .POS_WIDTH (POS_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (push && !job_full),
        .operation   (operation),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .heading_raw (heading_raw),
        .cfg_we      (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .job_push    (job_push),
        .job_data    (job_in),
        .gains       (gains)
    );

    gtp_queue #(
        .DATA_W (JOB_W)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_in),
        .rd_en   (job_pop),
        .rd_data (job_out),
        .full    (job_full),
        .empty   (job_empty)
    );

    gtp_back #(
        .POS_WIDTH    (POS_WIDTH),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .job_empty      (job_empty),
        .job_data       (job_out),
        .job_pop        (job_pop),
        .gains          (gains),
        .pop            (pop),
        .empty          (empty),
        .linear_speed   (linear_speed),
        .turn_rate      (turn_rate),
        .target_reached (target_reached),
        .fresh_command  (fresh_command)
    );

endmodule
